// ----- rtl/core/clipped_sprite_blitter_macros.svh -----
// Assertion macros for the clipped sprite blitter.
`ifndef CLIPPED_SPRITE_BLITTER_MACROS_SVH
`define CLIPPED_SPRITE_BLITTER_MACROS_SVH
`ifndef SYNTHESIS
`define CSB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csb assertion failed");
`define CSB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csb assertion failed");
`else
`define CSB_ASSERT_IMP(lbl, ante, cons)
`define CSB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/csb_pkg.sv -----
// Types, codes and defaults shared by the clipped sprite blitter modules.
package csb_pkg;

    localparam int CSB_MAX_WIDTH  = 512;
    localparam int CSB_MAX_HEIGHT = 256;
    localparam int CSB_MAX_SPRITE = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASKED   = 3'd6;

    localparam logic [1:0] MODE_SPRITE = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  pixel;
        logic [16:0] address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_pixel;
        logic       landed;
        logic       sprite_done;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  canvas_width;
        logic [8:0]  canvas_height;
        logic [8:0]  sprite_width;
        logic [8:0]  sprite_height;
        logic [10:0] dest_x;
        logic [10:0] dest_y;
        logic        masked;
    } t_cfg;

    typedef struct packed {
        logic landed;
        logic done;
    } t_place_flags;

    localparam t_cfg CFG_RESET = '{
        canvas_width:  10'd320,
        canvas_height: 9'd200,
        sprite_width:  9'd16,
        sprite_height: 9'd16,
        dest_x:        11'd0,
        dest_y:        11'd0,
        masked:        1'b1
    };

endpackage

// ----- rtl/core/csb_ram.sv -----
// Generic single-port RAM with registered read.
module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/csb_place.sv -----
// Sprite cursor, canvas clipping and linear address generation.
module csb_place #(
    parameter int MAX_WIDTH  = csb_pkg::CSB_MAX_WIDTH,
    parameter int MAX_HEIGHT = csb_pkg::CSB_MAX_HEIGHT,
    parameter int MAX_SPRITE = csb_pkg::CSB_MAX_SPRITE
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic                                     i_sprite,
    input  csb_pkg::t_cfg                            i_cfg,
    output csb_pkg::t_place_flags                    o_flags,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  o_lin_addr
);
    import csb_pkg::*;

    localparam int CW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_SPRITE);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PX_W  = ((COL_W + 1 > 11) ? COL_W + 1 : 11) + 1;
    localparam int LW    = YW + CW_W + 1;

    logic [COL_W-1:0]       r_col;
    logic [COL_W-1:0]       r_row;
    logic [COL_W-1:0]       n_col;
    logic [COL_W-1:0]       n_row;
    logic [COL_W-1:0]       sw_m1;
    logic [COL_W-1:0]       sh_m1;
    logic [CW_W-1:0]        cw;
    logic [CH_W-1:0]        ch;
    logic signed [PX_W-1:0] x;
    logic signed [PX_W-1:0] y;
    logic                   in_canvas;
    logic                   col_wrap;
    logic                   row_wrap;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic [LW-1:0]          lin;
    t_place_flags           r_flags;

    always_comb begin
        cw = (int'(i_cfg.canvas_width) > MAX_WIDTH) ? CW_W'(MAX_WIDTH)
                                                     : CW_W'(i_cfg.canvas_width);
        ch = (int'(i_cfg.canvas_height) > MAX_HEIGHT) ? CH_W'(MAX_HEIGHT)
                                                       : CH_W'(i_cfg.canvas_height);

        if (i_cfg.sprite_width == 9'd0) begin
            sw_m1 = '0;
        end else if (int'(i_cfg.sprite_width) > MAX_SPRITE) begin
            sw_m1 = COL_W'(MAX_SPRITE - 1);
        end else begin
            sw_m1 = COL_W'(i_cfg.sprite_width - 9'd1);
        end
        if (i_cfg.sprite_height == 9'd0) begin
            sh_m1 = '0;
        end else if (int'(i_cfg.sprite_height) > MAX_SPRITE) begin
            sh_m1 = COL_W'(MAX_SPRITE - 1);
        end else begin
            sh_m1 = COL_W'(i_cfg.sprite_height - 9'd1);
        end

        x = $signed({{(PX_W-11){i_cfg.dest_x[10]}}, i_cfg.dest_x})
          + $signed({{(PX_W-COL_W){1'b0}}, r_col});
        y = $signed({{(PX_W-11){i_cfg.dest_y[10]}}, i_cfg.dest_y})
          + $signed({{(PX_W-COL_W){1'b0}}, r_row});

        in_canvas = !x[PX_W-1] && !y[PX_W-1]
                 && (32'(unsigned'(x)) < 32'(cw))
                 && (32'(unsigned'(y)) < 32'(ch));

        col_wrap = (r_col >= sw_m1);
        row_wrap = (r_row >= sh_m1);

        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flags <= '0;
        end else if (i_load) begin
            r_flags.landed <= i_sprite && in_canvas;
            r_flags.done   <= i_sprite && col_wrap && row_wrap;
            if (i_sprite) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= XW'(unsigned'(x));
            r_y <= YW'(unsigned'(y));
        end
    end

    assign lin        = LW'(r_y) * LW'(cw) + LW'(r_x);
    assign o_lin_addr = AW'(lin);
    assign o_flags    = r_flags;

`include "clipped_sprite_blitter_macros.svh"

    `CSB_ASSERT_IMP(a_done_origin, r_flags.done, (r_col == '0) && (r_row == '0))
    `CSB_ASSERT_IMP(a_landed_sprite, r_flags.landed && $past(i_load), $past(i_sprite))

endmodule

// ----- rtl/core/clipped_sprite_blitter.sv -----
// Clipped transparent sprite blitter over an 8-bit indexed canvas held in one RAM.
// A transfer passes placement and clipping at the accepting edge, then linear address
// multiply, canvas RAM access and result capture. Items are handled one at a time, so
// no new item is accepted until the previous item's result is captured; the next item
// is accepted in the cycle after the result is captured, even while that result still
// waits in the output register. A result that finds the output register still full
// waits, and the input stays blocked until it moves. The canvas holds no contents
// after reset and needs no clearing pass; reading a location never written returns
// an undefined value.
// Sprite pixels (mode 0) place at dest plus an internal raster cursor, out-of-canvas
// pixels are dropped, and with masking on a zero index leaves the canvas untouched.
// Modes 1 and 2 write and read the canvas by linear address; mode 3 is a no-op.
module clipped_sprite_blitter #(
    parameter int MAX_WIDTH  = csb_pkg::CSB_MAX_WIDTH,
    parameter int MAX_HEIGHT = csb_pkg::CSB_MAX_HEIGHT,
    parameter int MAX_SPRITE = csb_pkg::CSB_MAX_SPRITE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  csb_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output csb_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [csb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import csb_pkg::*;

    localparam int FB_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(FB_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_MEM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    t_cfg          r_cfg;
    t_in_item      r_item;
    logic [AW-1:0] r_addr;
    logic          r_we;
    logic          r_re;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     result;
    t_place_flags  flags;
    logic [AW-1:0] lin_addr;
    logic [7:0]    ram_rdata;
    logic          in_xfer;
    logic          out_load;
    logic          addr_ok;
    logic          opaque;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign addr_ok    = (32'(r_item.address) < 32'(FB_DEPTH));
    assign opaque     = !(r_cfg.masked && (r_item.pixel == 8'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CANVAS_W: r_cfg.canvas_width  <= i_cfg_data[9:0];
                REG_CANVAS_H: r_cfg.canvas_height <= i_cfg_data[8:0];
                REG_SPRITE_W: r_cfg.sprite_width  <= i_cfg_data[8:0];
                REG_SPRITE_H: r_cfg.sprite_height <= i_cfg_data[8:0];
                REG_DEST_X:   r_cfg.dest_x        <= i_cfg_data[10:0];
                REG_DEST_Y:   r_cfg.dest_y        <= i_cfg_data[10:0];
                REG_MASKED:   r_cfg.masked        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    csb_place #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SPRITE (MAX_SPRITE)
    ) u_place (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_xfer),
        .i_sprite   (i_in_data.mode == MODE_SPRITE),
        .i_cfg      (r_cfg),
        .o_flags    (flags),
        .o_lin_addr (lin_addr)
    );

    csb_ram #(
        .WIDTH (8),
        .DEPTH (FB_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_en    ((r_state == ST_MEM) && (r_we || r_re)),
        .i_we    (r_we),
        .i_addr  (r_addr),
        .i_wdata (r_item.pixel),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_CALC;
            ST_CALC: n_state = ST_MEM;
            ST_MEM:  n_state = ST_DONE;
            ST_DONE: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        result.read_pixel  = r_re ? ram_rdata : 8'd0;
        result.landed      = flags.landed;
        result.sprite_done = flags.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_we        <= 1'b0;
            r_re        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_CALC) begin
                r_we <= ((r_item.mode == MODE_SPRITE) && flags.landed && opaque)
                     || ((r_item.mode == MODE_WRITE) && addr_ok);
                r_re <= (r_item.mode == MODE_READ) && addr_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_CALC) begin
            r_addr <= (r_item.mode == MODE_SPRITE) ? lin_addr : AW'(r_item.address);
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "clipped_sprite_blitter_macros.svh"

    `CSB_ASSERT_IMP(a_no_rw_both, r_state == ST_MEM, !(r_we && r_re))
    `CSB_ASSERT_IMP(a_wr_in_range, (r_state == ST_MEM) && r_we, 32'(r_addr) < 32'(FB_DEPTH))
    `CSB_ASSERT_NXT(a_result_shown, out_load, o_out_valid && o_in_ready)
    `CSB_ASSERT_IMP(a_read_excl, o_out_valid && (o_out_data.read_pixel != 8'd0), !o_out_data.landed && !o_out_data.sprite_done)

endmodule

// ----- tb/tb_clipped_sprite_blitter.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the clipped sprite blitter: directed and random transfers.
module tb_clipped_sprite_blitter;
    import csb_pkg::*;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int CANVAS_WORDS = CSB_MAX_WIDTH * CSB_MAX_HEIGHT;
    localparam int ITEM_TARGET = 1750;
    localparam int HOLD_CYCLES = 120;
    localparam int HOLD_EVERY = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    t_cfg cfg_shadow = CFG_RESET;
    bit [7:0] canvas_img [CANVAS_WORDS];
    bit addr_known [CANVAS_WORDS];
    int known_addrs [$];
    int cur_col = 0;
    int cur_row = 0;

    t_in_item blit_cmds [$];
    t_out_item blit_results_due [$];
    int send_idle_pct = 36;
    int recv_idle_pct = 48;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int landed_cnt = 0;
    int sprite_cnt = 0;
    int read_cnt = 0;
    int cfg_sets = 0;
    int holds_done = 0;
    int hold_left = 0;

    clipped_sprite_blitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int clamp_size(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void note_known(int a);
        if (!addr_known[a]) begin
            addr_known[a] = 1'b1;
            known_addrs.push_back(a);
        end
    endfunction

    function automatic t_out_item predict_blit(t_in_item cmd);
        t_out_item res;
        int cw, ch, sw, sh, x, y, a;
        res = '0;
        case (cmd.mode)
            MODE_SPRITE: begin
                cw = clamp_size(int'(cfg_shadow.canvas_width), 0, CSB_MAX_WIDTH);
                ch = clamp_size(int'(cfg_shadow.canvas_height), 0, CSB_MAX_HEIGHT);
                sw = clamp_size(int'(cfg_shadow.sprite_width), 1, CSB_MAX_SPRITE);
                sh = clamp_size(int'(cfg_shadow.sprite_height), 1, CSB_MAX_SPRITE);
                x = int'($signed(cfg_shadow.dest_x)) + cur_col;
                y = int'($signed(cfg_shadow.dest_y)) + cur_row;
                if (x >= 0 && y >= 0 && x < cw && y < ch) begin
                    a = y * cw + x;
                    res.landed = 1'b1;
                    landed_cnt++;
                    if (!(cfg_shadow.masked && cmd.pixel == 8'd0)) begin
                        canvas_img[a] = cmd.pixel;
                        note_known(a);
                    end
                end
                if (cur_col >= sw - 1) begin
                    cur_col = 0;
                    if (cur_row >= sh - 1) begin
                        cur_row = 0;
                        res.sprite_done = 1'b1;
                        sprite_cnt++;
                    end else begin
                        cur_row++;
                    end
                end else begin
                    cur_col++;
                end
            end
            MODE_WRITE: begin
                canvas_img[cmd.address] = cmd.pixel;
                note_known(int'(cmd.address));
            end
            MODE_READ: begin
                res.read_pixel = canvas_img[cmd.address];
                read_cnt++;
            end
            default: ;
        endcase
        return res;
    endfunction

    // pixels still needed, from the current cursor, until the sprite completes
    function automatic int pixels_to_sprite_end();
        int col, row, sw, sh, n;
        col = cur_col;
        row = cur_row;
        sw = clamp_size(int'(cfg_shadow.sprite_width), 1, CSB_MAX_SPRITE);
        sh = clamp_size(int'(cfg_shadow.sprite_height), 1, CSB_MAX_SPRITE);
        n = 0;
        forever begin
            n++;
            if (col >= sw - 1) begin
                col = 0;
                if (row >= sh - 1) return n;
                row++;
            end else begin
                col++;
            end
        end
    endfunction

    always @(posedge clk) begin : drv
        t_in_item nxt_item;
        logic nxt_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_item = in_data;
            if (in_valid && in_ready) begin
                blit_results_due.push_back(predict_blit(in_data));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && blit_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_item = blit_cmds.pop_front();
                nxt_valid = 1'b1;
            end
            in_valid <= nxt_valid;
            in_data <= nxt_item;
        end
    end

    always @(posedge clk) begin : mon
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (blit_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: read_pixel=%02h landed=%0b sprite_done=%0b",
                             $time, out_data.read_pixel, out_data.landed,
                             out_data.sprite_done);
                end else begin
                    want = blit_results_due.pop_front();
                    if (out_data.read_pixel !== want.read_pixel
                            || out_data.landed !== want.landed
                            || out_data.sprite_done !== want.sprite_done) begin
                        mismatches++;
                        $display("%0t: mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                 $time, want.read_pixel, want.landed, want.sprite_done,
                                 out_data.read_pixel, out_data.landed, out_data.sprite_done);
                    end
                end
            end
            // long back-pressure while the sender keeps offering
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (in_valid && holds_done < 2
                         && results_seen >= HOLD_EVERY * (holds_done + 1)) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_item(input logic [1:0] mode, input logic [7:0] px,
                             input logic [16:0] addr);
        t_in_item cmd;
        cmd.mode = mode;
        cmd.pixel = px;
        cmd.address = addr;
        blit_cmds.push_back(cmd);
        if (mode != MODE_NOP) items_sent++;
        if (mode == MODE_WRITE) note_known(int'(addr));
    endtask

    task automatic push_noise();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            push_item(MODE_WRITE, 8'($urandom_range(255)),
                      17'((roll < 20) ? $urandom_range(CANVAS_WORDS - 1)
                                      : $urandom_range(2047)));
        end else if (roll < 88 && known_addrs.size() > 0) begin
            push_item(MODE_READ, 8'($urandom_range(255)),
                      17'(known_addrs[$urandom_range(known_addrs.size() - 1)]));
        end else begin
            push_item(MODE_NOP, 8'($urandom_range(255)),
                      17'($urandom_range(CANVAS_WORDS - 1)));
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (blit_cmds.size() != 0 || in_valid || blit_results_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_CANVAS_W: cfg_shadow.canvas_width = val[9:0];
            REG_CANVAS_H: cfg_shadow.canvas_height = val[8:0];
            REG_SPRITE_W: cfg_shadow.sprite_width = val[8:0];
            REG_SPRITE_H: cfg_shadow.sprite_height = val[8:0];
            REG_DEST_X:   cfg_shadow.dest_x = val[10:0];
            REG_DEST_Y:   cfg_shadow.dest_y = val[10:0];
            REG_MASKED:   cfg_shadow.masked = val[0];
            default: ;
        endcase
    endtask

    task automatic write_cfg(input int cw, input int ch, input int sw, input int sh,
                             input int dx, input int dy, input int m);
        wait_drained();
        cfg_reg(REG_CANVAS_W, cw);
        cfg_reg(REG_CANVAS_H, ch);
        cfg_reg(REG_SPRITE_W, sw);
        cfg_reg(REG_SPRITE_H, sh);
        cfg_reg(REG_DEST_X, dx);
        cfg_reg(REG_DEST_Y, dy);
        cfg_reg(REG_MASKED, m);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_sets++;
        @(negedge clk);
    endtask

    task automatic stream_pixels(input int npix, input int noise_pct);
        int px;
        if (items_sent < ITEM_TARGET / 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 48;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 36;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(99) < noise_pct) push_noise();
            px = ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
            push_item(MODE_SPRITE, 8'(px), 17'($urandom_range(CANVAS_WORDS - 1)));
        end
    endtask

    task automatic random_phase();
        int cw, ch, sw, sh, dx, dy, roll, spx, npix;
        roll = $urandom_range(9);
        cw = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(513, 1023)
           : (roll == 2) ? 512 : $urandom_range(1, 40);
        roll = $urandom_range(9);
        ch = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(257, 511)
           : (roll == 2) ? 256 : $urandom_range(1, 40);
        roll = $urandom_range(11);
        sw = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(257, 511)
           : (roll == 2) ? 256 : $urandom_range(1, 8);
        roll = $urandom_range(11);
        sh = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(257, 511)
           : (roll == 2) ? 256 : $urandom_range(1, 8);
        if ($urandom_range(7) == 0)
            dx = int'($urandom_range(2047)) - 1024;
        else
            dx = int'($urandom_range(clamp_size(cw, 0, CSB_MAX_WIDTH) + 8)) - 6;
        if ($urandom_range(7) == 0)
            dy = int'($urandom_range(2047)) - 1024;
        else
            dy = int'($urandom_range(clamp_size(ch, 0, CSB_MAX_HEIGHT) + 8)) - 6;
        write_cfg(cw, ch, sw, sh, dx, dy, $urandom_range(1));
        spx = clamp_size(sw, 1, CSB_MAX_SPRITE) * clamp_size(sh, 1, CSB_MAX_SPRITE);
        if (spx <= 64) begin
            npix = pixels_to_sprite_end() + spx * $urandom_range(2);
            if ($urandom_range(7) == 0) npix += $urandom_range(1, 6);
        end else begin
            npix = $urandom_range(20, 60);
        end
        stream_pixels(npix, 20);
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: address extremes, all modes, transparency, overwrite
        push_item(MODE_WRITE, 8'hFF, 17'd0);
        push_item(MODE_WRITE, 8'h00, 17'h1FFFF);
        push_item(MODE_WRITE, 8'h55, 17'h0AAAA);
        push_item(MODE_WRITE, 8'hAA, 17'h15555);
        push_item(MODE_READ, 8'h00, 17'h1FFFF);
        push_item(MODE_READ, 8'hFF, 17'h0AAAA);
        push_item(MODE_READ, 8'h00, 17'h15555);
        push_item(MODE_READ, 8'h00, 17'd0);
        push_item(MODE_NOP, 8'hFF, 17'h1FFFF);
        push_item(MODE_NOP, 8'h00, 17'd0);
        push_item(MODE_SPRITE, 8'h00, 17'd0);
        push_item(MODE_SPRITE, 8'hFF, 17'h1FFFF);
        push_item(MODE_SPRITE, 8'h01, 17'd0);
        push_item(MODE_READ, 8'h00, 17'd0);
        push_item(MODE_READ, 8'h00, 17'd1);
        push_item(MODE_READ, 8'h00, 17'd2);
        write_cfg(320, 200, 16, 16, -1, 0, 0);
        push_item(MODE_SPRITE, 8'h00, 17'd0);
        push_item(MODE_READ, 8'h00, 17'd2);

        // maximum-width sprite on the bottom row of the largest canvas
        write_cfg(512, 256, 256, 1, 0, 255, 0);
        stream_pixels(pixels_to_sprite_end(), 0);
        // zero sprite width, oversize height, one-pixel canvas
        write_cfg(1, 1, 0, 511, 0, -100, 1);
        stream_pixels(pixels_to_sprite_end(), 5);
        // oversize canvas, clipped at the far corner
        write_cfg(1023, 511, 3, 2, 510, 255, 1);
        stream_pixels(pixels_to_sprite_end() + 6, 10);
        // empty canvas
        write_cfg(0, 0, 4, 4, -1024, 1023, 0);
        stream_pixels(pixels_to_sprite_end(), 10);
        // sprite shrinks while the cursor is past its new size
        write_cfg(64, 64, 8, 8, -3, -2, 1);
        stream_pixels(20, 0);
        write_cfg(64, 64, 2, 2, -3, -2, 1);
        stream_pixels(10, 0);

        while (items_sent < ITEM_TARGET) random_phase();

        wait_drained();
        repeat (10) @(negedge clk);
        if (blit_results_due.size() != 0) begin
            mismatches += blit_results_due.size();
            $display("%0t: %0d expected results never arrived", $time,
                     blit_results_due.size());
        end
        $display("Ran %0d transfers over %0d register settings, %0d canvas reads checked.",
                 items_sent, cfg_sets, read_cnt);
        $display("%0d sprite pixels landed, %0d sprites completed, %0d results compared.",
                 landed_cnt, sprite_cnt, results_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
